@@ rtl/u8e_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8e_pkg
// Shared types, status codes and encoding helpers for the UCS-4 to UTF-8
// encoder.
// ----------------------------------------------------------------------------
package u8e_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_STOPPED = 2'd2;

    localparam logic [15:0] BUDGET_RESET = 16'd256;

    typedef struct packed {
        logic [31:0] code_point;
        logic        last_point;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        run_end;
        logic [1:0]  status;
        logic [15:0] bytes_total;
        logic [15:0] points_used;
    } t_out_item;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic [30:0] code_point;
        logic [2:0]  count;
        logic        byte_valid;
        logic [1:0]  status;
        logic [15:0] bytes_base;
        logic [15:0] points_used;
    } t_cmd;

    // Number of bytes in the six-byte form, zero for values above 0x7fffffff.
    function automatic logic [2:0] seq_length(input logic [31:0] cp);
        logic [2:0] len;
        begin
            if (cp < 32'h0000_0080) begin
                len = 3'd1;
            end else if (cp < 32'h0000_0800) begin
                len = 3'd2;
            end else if (cp < 32'h0001_0000) begin
                len = 3'd3;
            end else if (cp < 32'h0020_0000) begin
                len = 3'd4;
            end else if (cp < 32'h0400_0000) begin
                len = 3'd5;
            end else if (cp <= 32'h7fff_ffff) begin
                len = 3'd6;
            end else begin
                len = 3'd0;
            end
            return len;
        end
    endfunction

    function automatic logic [7:0] lead_mark(input logic [2:0] len);
        logic [7:0] mark;
        begin
            unique case (len)
                3'd2:    mark = 8'hc0;
                3'd3:    mark = 8'he0;
                3'd4:    mark = 8'hf0;
                3'd5:    mark = 8'hf8;
                3'd6:    mark = 8'hfc;
                default: mark = 8'h00;
            endcase
            return mark;
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/u8e_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8e_front
// Classifies each accepted code point against the string counters and the
// byte budget, updates the counters and issues one request to the back end.
// ----------------------------------------------------------------------------
module u8e_front
    import u8e_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    output t_cmd          o_cmd
);

    logic [15:0] r_budget;
    logic [15:0] r_bytes;
    logic [15:0] r_points;
    logic        r_stopped;

    logic [15:0] n_bytes;
    logic [15:0] n_points;
    logic        n_stopped;

    logic [2:0]  len;
    logic [16:0] sum;
    logic [15:0] points_inc;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        len        = seq_length(i_item.code_point);
        sum        = {1'b0, r_bytes} + {14'd0, len};
        points_inc = (r_points == 16'hffff) ? r_points : r_points + 16'd1;

        n_bytes   = r_bytes;
        n_points  = r_points;
        n_stopped = r_stopped;

        o_cmd.code_point  = i_item.code_point[30:0];
        o_cmd.count       = 3'd1;
        o_cmd.byte_valid  = 1'b0;
        o_cmd.bytes_base  = r_bytes;
        o_cmd.status      = ST_STOPPED;
        o_cmd.points_used = r_points;

        priority if (r_stopped) begin
            o_cmd.status = ST_STOPPED;
        end else if (len == 3'd0) begin
            n_points          = points_inc;
            o_cmd.status      = ST_ILLEGAL;
            o_cmd.points_used = points_inc;
        end else if (sum > {1'b0, r_budget}) begin
            n_stopped    = 1'b1;
            o_cmd.status = ST_STOPPED;
        end else begin
            n_bytes           = sum[15:0];
            n_points          = points_inc;
            o_cmd.status      = ST_OK;
            o_cmd.count       = len;
            o_cmd.byte_valid  = 1'b1;
            o_cmd.points_used = points_inc;
        end

        if (i_item.last_point) begin
            n_bytes   = 16'd0;
            n_points  = 16'd0;
            n_stopped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget  <= BUDGET_RESET;
            r_bytes   <= 16'd0;
            r_points  <= 16'd0;
            r_stopped <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_budget <= i_cfg_data;
            end
            if (i_accept) begin
                r_bytes   <= n_bytes;
                r_points  <= n_points;
                r_stopped <= n_stopped;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/u8e_cmd_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8e_cmd_queue
// Small first-in first-out queue of classified requests between the front
// and the back end.
// ----------------------------------------------------------------------------
module u8e_cmd_queue
    import u8e_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_data,
    output logic      o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/u8e_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8e_back
// Expands each request into its result items, one per cycle as long as the
// receiver drains the output register that holds them.
// ----------------------------------------------------------------------------
module u8e_back
    import u8e_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire logic i_cmd_empty,
    output logic      o_cmd_pop,
    output t_out_item o_result,
    output logic      o_empty,
    input  wire logic i_pop
);

    logic        r_out_valid;
    t_out_item   r_out;
    logic [2:0]  r_idx;

    logic        advance;
    logic        last_res;
    logic [2:0]  remain;
    logic [4:0]  shift;
    logic [30:0] shifted;
    t_out_item   n_out;

    assign advance   = !i_cmd_empty && (!r_out_valid || i_pop);
    assign last_res  = (r_idx == i_cmd.count - 3'd1);
    assign o_cmd_pop = advance && last_res;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    always_comb begin
        remain  = i_cmd.count - 3'd1 - r_idx;
        shift   = {remain, 2'b00} + {1'b0, remain, 1'b0};
        shifted = i_cmd.code_point >> shift;

        n_out.byte_valid  = i_cmd.byte_valid;
        n_out.run_end     = last_res;
        n_out.status      = i_cmd.status;
        n_out.points_used = i_cmd.points_used;
        if (!i_cmd.byte_valid) begin
            n_out.out_byte    = 8'h00;
            n_out.bytes_total = i_cmd.bytes_base;
        end else begin
            if (r_idx == 3'd0) begin
                n_out.out_byte = lead_mark(i_cmd.count) | shifted[7:0];
            end else begin
                n_out.out_byte = {2'b10, shifted[5:0]};
            end
            n_out.bytes_total = i_cmd.bytes_base + {13'd0, r_idx} + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 3'd0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_idx       <= last_res ? 3'd0 : r_idx + 3'd1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/ucs4_to_utf8_encoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ucs4_to_utf8_encoder
// Encodes 32-bit code points into UTF-8 bytes in the original six-byte form.
// ----------------------------------------------------------------------------
// The input side is a queue: write a code point with push while full is low.
// The result side is a queue too: while empty is low, o_result holds the
// oldest result, and pop takes it away. Each code point gives one to six
// results, one byte each, or a single status result with no byte.
// The front classifies a point in the cycle it is accepted and updates the
// string counters; a command queue of QUEUE_DEPTH entries feeds the back end.
// A point accepted into the command queue has its first result on the ports
// once the back end has loaded it into the output register. The back end
// emits one result per cycle while the receiver keeps popping, one to six
// per point; the byte serializer sets the throughput.
// If the receiver stops popping, the output register holds, the command queue
// fills and full rises; nothing is lost.
// The budget register takes a request on the configuration channel at any
// cycle; it is always ready and should be written only while the block is idle.
// Reset clears the counters and both queues and sets the budget to 256.
// ----------------------------------------------------------------------------
module ucs4_to_utf8_encoder
    import u8e_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire t_in_item    i_item,
    output logic             empty,
    input  wire logic        pop,
    output t_out_item        o_result,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    logic accept;
    t_cmd front_cmd;
    t_cmd head_cmd;
    logic q_empty;
    logic q_pop;

    assign accept = push && !full;

    u8e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_cmd       (front_cmd)
    );

    u8e_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (head_cmd),
        .o_empty (q_empty)
    );

    u8e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule
`default_nettype wire
